>>> src/int_to_decimal_ascii_defines.svh
// ============================================================================
// Assertion macros for the integer to decimal text converter
// Shared helpers that wrap concurrent assertions clocked on one edge and
// disabled while the active-low reset is asserted.
// ============================================================================
`ifndef INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_DEFINES_SVH

// The property must hold at every rising edge outside reset.
`define ITDA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ITDA_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> src/itda_pkg.sv
// ============================================================================
// Package for the integer to decimal text converter
// Field widths, channel widths and character codes shared by the design
// and its port checker.
// ============================================================================
package itda_pkg;

    // Input integer and packed stream widths.
    localparam int VALUE_W  = 32;
    localparam int S_DATA_W = 32;
    localparam int CODE_W   = 6;
    localparam int M_DATA_W = 8;

    // Decimal digit store: ten BCD digits cover every 32-bit magnitude.
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    // One shift-and-adjust step per magnitude bit.
    localparam int CONV_STEPS = VALUE_W;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    // ASCII codes, trimmed to the character field width.
    localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CODE_W-1:0] CHAR_NINE  = 6'd57;

endpackage

>>> src/int_to_decimal_ascii.sv
// ============================================================================
// Signed 32-bit integer to decimal ASCII text
// Converts one two's complement integer per request into its decimal text,
// one character per output request, sign first, no leading zeros.
// ============================================================================
//
//  Channel   Direction  Payload                              Marker
//  s_        in         tdata[31:0] value                    -
//  m_        out        tdata[5:0] char_code, [7:6] zero     tlast = last
//
//  An integer passes through the BCD shift-and-adjust unit, which handles
//  one magnitude bit per cycle, then a step that locates the leading digit,
//  and its characters then go out one per output request.
//  Reset is synchronous on aresetn low and returns the block to idle.
//  A stall on the output holds the character register and, in ST_EMIT, the sequencer;
//  a new request is taken while the last character still waits.
//
module int_to_decimal_ascii (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [itda_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [itda_pkg::M_DATA_W-1:0] m_tdata,   // [5:0] char_code, [7:6] zero
    output logic                          m_tlast
);
    import itda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [DIGIT_W-1:0]    digit_reg [NUM_DIGITS];
    logic [DIGIT_W-1:0]    digit_next [NUM_DIGITS];
    logic [DIGIT_W-1:0]    digit_adj [NUM_DIGITS];
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      lead_idx;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic                  last_reg, last_next;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_adj[i] = (digit_reg[i] >= DIGIT_W'(5)) ? digit_reg[i] + DIGIT_W'(3)
                                                           : digit_reg[i];
        end
    end

    // Position of the most significant nonzero digit; zero gives position 0.
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (digit_reg[i] != '0) begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    // Sequencer: load, convert bit by bit, locate the first digit, emit.
    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        digit_next    = digit_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        code_next     = code_reg;
        last_next     = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // The magnitude of the most negative value still fits unsigned.
                    neg_next = s_tdata[VALUE_W-1];
                    mag_next = s_tdata[VALUE_W-1] ? (~s_tdata + VALUE_W'(1)) : s_tdata;
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        digit_next[i] = '0;
                    end
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                // Shift the adjusted digits left, pulling in the next magnitude bit.
                digit_next[0] = {digit_adj[0][DIGIT_W-2:0], mag_reg[VALUE_W-1]};
                for (int i = 1; i < NUM_DIGITS; i++) begin
                    digit_next[i] = {digit_adj[i][DIGIT_W-2:0], digit_adj[i-1][DIGIT_W-1]};
                end
                mag_next  = {mag_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_STEPS - 1)) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                idx_next   = lead_idx;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // Load the next character whenever the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (neg_reg) begin
                        code_next = CHAR_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end else begin
                        code_next = CHAR_ZERO + CODE_W'(digit_reg[idx_reg]);
                        last_next = (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        digit_reg <= digit_next;
        step_reg  <= step_next;
        idx_reg   <= idx_next;
        code_reg  <= code_next;
        last_reg  <= last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - CODE_W){1'b0}}, code_reg};
    assign m_tlast  = last_reg;

endmodule

>>> src/int_to_decimal_ascii_checker.sv
// ============================================================================
// Port checker for the integer to decimal text converter
// Watches the stream ports of the converter and flags behavior that the
// character stream must never show.
// ============================================================================
`include "int_to_decimal_ascii_defines.svh"

module int_to_decimal_ascii_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [itda_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] value
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [itda_pkg::M_DATA_W-1:0] m_tdata,   // [5:0] char_code, [7:6] zero
    input logic                          m_tlast
);
    import itda_pkg::*;

    logic [CODE_W-1:0] code;
    logic              in_taken;

    assign code     = m_tdata[CODE_W-1:0];
    assign in_taken = s_tvalid && s_tready && (s_tdata == s_tdata);

    // A stalled character keeps its code and marker.
    `ITDA_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled character changed")

    // Only a minus sign or a decimal digit is ever sent, with zero padding.
    `ITDA_ASSERT(a_code_range, aclk, aresetn, m_tvalid |-> ((code == CHAR_MINUS || (code >= CHAR_ZERO && code <= CHAR_NINE)) && m_tdata[M_DATA_W-1:CODE_W] == '0), "character code out of range")

    // The sign is never the final character of a number.
    `ITDA_ASSERT_NEVER(a_minus_last, aclk, aresetn, m_tvalid && code == CHAR_MINUS && m_tlast, "minus sign marked last")

    // Conversion starts at once: no second request is taken right after one.
    `ITDA_ASSERT(a_busy_after_take, aclk, aresetn, in_taken |=> !s_tready, "request taken during conversion")

endmodule

bind int_to_decimal_ascii int_to_decimal_ascii_checker u_checker (.*);

>>> test/itda_text_checker.sv
// ============================================================================
// Decimal text checker for the integer to decimal ASCII converter
// Watches both stream channels. Every accepted input request is spelled out
// into the characters the block must emit, and every accepted output request
// is compared against the oldest character still owed.
// ============================================================================
`timescale 1ns / 100ps

module itda_text_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [itda_pkg::S_DATA_W-1:0] s_tdata,    // [31:0] value
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [itda_pkg::M_DATA_W-1:0] m_tdata,    // [5:0] char_code, [7:6] zero
    input  logic                          m_tlast,
    output int                            chars_pending,
    output int                            mismatch_count
);
    import itda_pkg::*;

    localparam int DECIMAL_BASE = 10;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } text_char_t;

    // Characters owed by the block, oldest first.
    text_char_t owed_chars[$];

    initial begin
        chars_pending  = 0;
        mismatch_count = 0;
    end

    // Spell one integer as decimal text: optional sign, then digits with no
    // leading zeros. The magnitude is one bit wider so the most negative
    // value negates cleanly.
    function automatic void spell_decimal(input logic [VALUE_W-1:0] value);
        logic [VALUE_W:0]  magnitude;
        logic [DIGIT_W-1:0] digits [NUM_DIGITS];
        int                ndigits;
        text_char_t        ch;

        magnitude = value[VALUE_W-1] ? {1'b0, ~value} + 1'b1 : {1'b0, value};
        ndigits   = 0;
        do begin
            digits[ndigits] = DIGIT_W'(magnitude % DECIMAL_BASE);
            magnitude       = magnitude / DECIMAL_BASE;
            ndigits++;
        end while (magnitude != 0 && ndigits < NUM_DIGITS);

        if (value[VALUE_W-1]) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            owed_chars.push_back(ch);
        end
        for (int k = ndigits - 1; k >= 0; k--) begin
            ch.code = CHAR_ZERO + digits[k];
            ch.last = (k == 0);
            owed_chars.push_back(ch);
        end
    endfunction

    // Predict on input requests and compare on output requests.
    always @(posedge aclk) begin
        text_char_t wanted;

        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                spell_decimal(s_tdata[VALUE_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                if (owed_chars.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected character: expected none, got code %0d last %0b",
                             $time, m_tdata[CODE_W-1:0], m_tlast);
                end else begin
                    wanted = owed_chars.pop_front();
                    if (m_tdata[CODE_W-1:0] !== wanted.code) begin
                        mismatch_count++;
                        $display("%0t: char_code mismatch: expected %0d, got %0d",
                                 $time, wanted.code, m_tdata[CODE_W-1:0]);
                    end
                    if (m_tlast !== wanted.last) begin
                        mismatch_count++;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, wanted.last, m_tlast);
                    end
                end
                // The bits above the character code are padding and must be zero.
                if (m_tdata[M_DATA_W-1:CODE_W] !== '0) begin
                    mismatch_count++;
                    $display("%0t: tdata padding mismatch: expected 0, got %0h",
                             $time, m_tdata[M_DATA_W-1:CODE_W]);
                end
            end
            chars_pending <= owed_chars.size();
        end
    end

endmodule

>>> test/tb_int_to_decimal_ascii.sv
// ============================================================================
// Testbench for the integer to decimal ASCII converter
// Sends directed corner values and then a few hundred random integers of
// mixed magnitude and sign in random bursts, while the output side stalls in
// shifting patterns, including one long hold-off that backs up the input.
// The checker instance judges every character; this module gives the verdict.
// ============================================================================
`timescale 1ns / 100ps

module tb_int_to_decimal_ascii;
    import itda_pkg::*;

    localparam int NUM_RANDOM  = 260;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLDOFF_LEN = 600;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;      // [31:0] value
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;            // [5:0] char_code, [7:6] zero
    logic                m_tlast;

    int chars_pending;
    int mismatch_count;
    int cycle_count = 0;

    // Powers of ten give the digit-count boundaries.
    logic [VALUE_W-1:0] powers_of_ten [NUM_DIGITS] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    int_to_decimal_ascii i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    itda_text_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .chars_pending  (chars_pending),
        .mismatch_count (mismatch_count)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side: a short random phase, one long hold-off while the sender
    // keeps offering requests, then stall patterns of random kind and length.
    initial begin
        int mode;
        int span;

        while (!aresetn) @(posedge aclk);
        repeat (150) @(posedge aclk) m_tready <= ($urandom_range(0, 3) != 0);
        @(posedge aclk);
        m_tready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 300);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Input side: directed corners, then random values, sent in bursts.
    initial begin
        logic [VALUE_W-1:0] values_to_send[$];
        logic [VALUE_W-1:0] v;
        int                 next_item;
        int                 burst_len;
        int                 gap_len;

        // Zero, single digits, digit-count boundaries, both extremes,
        // alternating bit patterns and minus one.
        values_to_send = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            32'h7FFF_FFFF, 32'h8000_0000, 32'd1000000000, -32'sd1000000000,
            32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
            32'd123456789, -32'sd987654321, 32'h8000_0001, -32'sd7
        };

        // Random values spread over every digit count and both signs.
        repeat (NUM_RANDOM) begin
            case ($urandom_range(0, 3))
                0:       v = $urandom;
                1:       v = $urandom_range(0, 99);
                2:       v = $urandom >> $urandom_range(1, 31);
                default: v = powers_of_ten[$urandom_range(0, NUM_DIGITS - 1)]
                             - $urandom_range(0, 1);
            endcase
            if ($urandom_range(0, 1) == 1) begin
                v = -v;
            end
            values_to_send.push_back(v);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        next_item = 0;
        while (next_item < values_to_send.size()) begin
            burst_len = $urandom_range(1, 8);
            while (burst_len > 0 && next_item < values_to_send.size()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= values_to_send[next_item];
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                next_item++;
                burst_len--;
            end
            // Gaps up to longer than one conversion so they land in every phase.
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap_len != 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap_len) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // Let the last request reach the checker, then drain all characters.
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
